// File: rtl/bpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

	localparam int NUM_COEF  = 11;
	localparam int DIV_W     = 32;
	localparam int DIV_STEPS = DIV_W;

	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_COMPUTE = 1'b1;

	localparam logic [3:0] IDX_AC1 = 4'd0;
	localparam logic [3:0] IDX_AC2 = 4'd1;
	localparam logic [3:0] IDX_AC3 = 4'd2;
	localparam logic [3:0] IDX_AC4 = 4'd3;
	localparam logic [3:0] IDX_AC5 = 4'd4;
	localparam logic [3:0] IDX_AC6 = 4'd5;
	localparam logic [3:0] IDX_B1  = 4'd6;
	localparam logic [3:0] IDX_B2  = 4'd7;
	localparam logic [3:0] IDX_MB  = 4'd8;
	localparam logic [3:0] IDX_MC  = 4'd9;
	localparam logic [3:0] IDX_MD  = 4'd10;

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_DIV0   = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [3:0]  coef_index;
		logic [15:0] coef_value;
		logic [15:0] raw_temp;
		logic [15:0] raw_press;
	} item_t;

	typedef struct packed {
		logic signed [31:0] pressure_pa;
		logic               status;
	} result_t;

	// State of one restoring division step.
	typedef struct packed {
		logic [DIV_W-1:0] rem;
		logic [DIV_W-1:0] num;
		logic [DIV_W-1:0] quo;
		logic [DIV_W-1:0] den;
	} div_st_t;

	// Values that ride alongside the temperature division.
	typedef struct packed {
		logic               err;
		logic               neg;
		logic signed [31:0] x1;
		logic signed [15:0] ac1;
		logic signed [15:0] ac2;
		logic signed [15:0] ac3;
		logic [15:0]        ac4;
		logic signed [15:0] b1;
		logic signed [15:0] b2;
		logic [15:0]        up;
	} sb1_t;

	// Values that ride alongside the pressure division.
	typedef struct packed {
		logic err;
		logic big;
	} sb2_t;

endpackage

`default_nettype wire

// File: rtl/barometric_pressure_compensation.sv
// Compute beats pass s1-s2, the T divider, c1-c6, the P divider, d1-d2, the output.
// Throughput: one beat per cycle unless stalled; two 32-stage dividers set the depth.
// A load beat writes its calibration word (index below 11) at acceptance; no result.
// Reset (arst_n low, asynchronous) clears all valid bits and the calibration words.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module barometric_pressure_compensation import bpc_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_ready,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_ready,
	output result_t      result
);

	// The pipeline moves as one: it advances whenever the output register is free.
	logic adv;
	logic acc;

	// Calibration words, read at fixed places.
	logic [15:0] cal_q [NUM_COEF];

	assign acc = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEF; i++) cal_q[i] <= '0;
		end else if (acc && item.kind == KIND_LOAD && item.coef_index < 4'(NUM_COEF)) begin
			cal_q[item.coef_index] <= item.coef_value;
		end
	end

	// Stage 1: first temperature term and the temperature divisor.
	logic signed [17:0] ut_m_ac6;
	logic signed [34:0] x1_prod;
	logic signed [31:0] x1_c;
	logic signed [31:0] tdiv_c;

	logic               v_s1;
	logic signed [31:0] x1_s1;
	logic signed [31:0] tdiv_s1;
	logic signed [15:0] mc_s1;
	sb1_t               sb_s1;

	always_comb begin
		ut_m_ac6 = $signed({2'b00, item.raw_temp}) - $signed({2'b00, cal_q[IDX_AC6]});
		x1_prod  = ut_m_ac6 * $signed({19'b0, cal_q[IDX_AC5]});
		x1_c     = {{12{x1_prod[34]}}, x1_prod[34:15]};
		tdiv_c   = x1_c + {{16{cal_q[IDX_MD][15]}}, cal_q[IDX_MD]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc && item.kind == KIND_COMPUTE;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x1_s1      <= x1_c;
			tdiv_s1    <= tdiv_c;
			mc_s1      <= $signed(cal_q[IDX_MC]);
			sb_s1.err  <= 1'b0;
			sb_s1.neg  <= 1'b0;
			sb_s1.x1   <= x1_c;
			sb_s1.ac1  <= $signed(cal_q[IDX_AC1]);
			sb_s1.ac2  <= $signed(cal_q[IDX_AC2]);
			sb_s1.ac3  <= $signed(cal_q[IDX_AC3]);
			sb_s1.ac4  <= cal_q[IDX_AC4];
			sb_s1.b1   <= $signed(cal_q[IDX_B1]);
			sb_s1.b2   <= $signed(cal_q[IDX_B2]);
			sb_s1.up   <= item.raw_press;
		end
	end

	// Stage 2: magnitudes and sign for the signed division MC*2048 / (X1+MD).
	logic signed [26:0] tnum;
	sb1_t               sb2_in;
	logic               v_s2;
	logic [DIV_W-1:0]   num1_s2;
	logic [DIV_W-1:0]   den1_s2;
	sb1_t               sb_s2;

	assign tnum = {mc_s1, 11'b0};

	always_comb begin
		sb2_in     = sb_s1;
		sb2_in.err = (tdiv_s1 == '0);
		sb2_in.neg = tnum[26] ^ tdiv_s1[31];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num1_s2    <= tnum[26] ? DIV_W'(-{{5{tnum[26]}}, tnum}) : DIV_W'(tnum);
			den1_s2    <= tdiv_s1[31] ? DIV_W'(-tdiv_s1) : DIV_W'(tdiv_s1);
			sb_s2      <= sb2_in;
		end
	end

	// Temperature division, with its side values delayed to match.
	logic [DIV_W-1:0] quo1;
	logic             v1_d [DIV_STEPS];
	sb1_t             sb1_d [DIV_STEPS];

	bpc_div u_div_t (
		.clk (clk),
		.en  (adv),
		.num (num1_s2),
		.den (den1_s2),
		.quo (quo1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_STEPS; i++) v1_d[i] <= 1'b0;
		end else if (adv) begin
			v1_d[0] <= v_s2;
			for (int i = 1; i < DIV_STEPS; i++) v1_d[i] <= v1_d[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sb1_d[0] <= sb_s2;
			for (int i = 1; i < DIV_STEPS; i++) sb1_d[i] <= sb1_d[i-1];
		end
	end

	// Stage c1: B5 and B6.
	logic signed [31:0] x2_t;
	logic               v_c1;
	logic signed [31:0] b6_c1;
	sb1_t               sb_c1;

	assign x2_t = sb1_d[DIV_STEPS-1].neg ? -$signed(quo1) : $signed(quo1);

	always_ff @(posedge clk) begin
		if (adv) begin
			b6_c1 <= sb1_d[DIV_STEPS-1].x1 + x2_t - 32'sd4000;
			sb_c1 <= sb1_d[DIV_STEPS-1];
		end
	end

	// Stage c2: the square of B6 and the two products with B6.
	logic signed [63:0] m_sq;
	logic signed [63:0] m_ac2;
	logic signed [63:0] m_ac3;
	logic               v_c2;
	logic signed [31:0] sq_c2;
	logic signed [31:0] x2a_c2;
	logic signed [31:0] x1b_c2;
	sb1_t               sb_c2;

	always_comb begin
		m_sq  = b6_c1 * b6_c1;
		m_ac2 = sb_c1.ac2 * b6_c1;
		m_ac3 = sb_c1.ac3 * b6_c1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_c2  <= m_sq[43:12];
			x2a_c2 <= m_ac2[42:11];
			x1b_c2 <= m_ac3[44:13];
			sb_c2  <= sb_c1;
		end
	end

	// Stage c3: products with the square.
	logic signed [63:0] m_b2;
	logic signed [63:0] m_b1;
	logic               v_c3;
	logic signed [31:0] x1a_c3;
	logic signed [31:0] x2a_c3;
	logic signed [31:0] x1b_c3;
	logic signed [31:0] x2b_c3;
	sb1_t               sb_c3;

	always_comb begin
		m_b2 = sb_c2.b2 * sq_c2;
		m_b1 = sb_c2.b1 * sq_c2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x1a_c3 <= m_b2[42:11];
			x2b_c3 <= m_b1[47:16];
			x2a_c3 <= x2a_c2;
			x1b_c3 <= x1b_c2;
			sb_c3  <= sb_c2;
		end
	end

	// Stage c4: B3 (rounded and divided by four toward zero) and the X3 of B4.
	logic signed [31:0] x3_t;
	logic signed [31:0] s_t;
	logic signed [33:0] t34;
	logic signed [33:0] t34r;
	logic signed [31:0] u_t;
	logic signed [32:0] v33;
	logic               v_c4;
	logic signed [31:0] b3_c4;
	logic signed [31:0] x3b_c4;
	sb1_t               sb_c4;

	always_comb begin
		x3_t = x1a_c3 + x2a_c3;
		s_t  = {{14{sb_c3.ac1[15]}}, sb_c3.ac1, 2'b00} + x3_t;
		t34  = {{2{s_t[31]}}, s_t} + 34'sd2;
		t34r = t34[33] ? t34 + 34'sd3 : t34;
		u_t  = x1b_c3 + x2b_c3;
		v33  = {u_t[31], u_t} + 33'sd2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b3_c4  <= t34r[33:2];
			x3b_c4 <= {v33[32], v33[32:2]};
			sb_c4  <= sb_c3;
		end
	end

	// Stage c5: B4 and B7.
	logic [31:0] x3u;
	logic [47:0] m_b4;
	logic [31:0] upb3;
	logic [47:0] m_b7;
	logic        v_c5;
	logic [31:0] b4_c5;
	logic [31:0] b7_c5;
	logic        err_c5;

	always_comb begin
		x3u  = x3b_c4 + 32'sd32768;
		m_b4 = sb_c4.ac4 * x3u;
		upb3 = {16'b0, sb_c4.up} - b3_c4;
		m_b7 = upb3 * 16'd50000;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b4_c5  <= m_b4[46:15];
			b7_c5  <= m_b7[31:0];
			err_c5 <= sb_c4.err;
		end
	end

	// Stage c6: dividend for the pressure division and the second divisor check.
	logic             v_c6;
	logic [DIV_W-1:0] num2_c6;
	logic [DIV_W-1:0] den2_c6;
	sb2_t             sb_c6;

	always_ff @(posedge clk) begin
		if (adv) begin
			num2_c6    <= b7_c5[31] ? b7_c5 : {b7_c5[30:0], 1'b0};
			den2_c6    <= b4_c5;
			sb_c6.big  <= b7_c5[31];
			sb_c6.err  <= err_c5 || (b4_c5 == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c1 <= 1'b0;
			v_c2 <= 1'b0;
			v_c3 <= 1'b0;
			v_c4 <= 1'b0;
			v_c5 <= 1'b0;
			v_c6 <= 1'b0;
		end else if (adv) begin
			v_c1 <= v1_d[DIV_STEPS-1];
			v_c2 <= v_c1;
			v_c3 <= v_c2;
			v_c4 <= v_c3;
			v_c5 <= v_c4;
			v_c6 <= v_c5;
		end
	end

	// Pressure division.
	logic [DIV_W-1:0] quo2;
	logic             v2_d [DIV_STEPS];
	sb2_t             sb2_d [DIV_STEPS];

	bpc_div u_div_p (
		.clk (clk),
		.en  (adv),
		.num (num2_c6),
		.den (den2_c6),
		.quo (quo2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_STEPS; i++) v2_d[i] <= 1'b0;
		end else if (adv) begin
			v2_d[0] <= v_c6;
			for (int i = 1; i < DIV_STEPS; i++) v2_d[i] <= v2_d[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sb2_d[0] <= sb_c6;
			for (int i = 1; i < DIV_STEPS; i++) sb2_d[i] <= sb2_d[i-1];
		end
	end

	// Stage d1: P, the square of P/256 and the linear correction term.
	logic signed [31:0] p_t;
	logic signed [23:0] p8_t;
	logic signed [47:0] m_p8;
	logic signed [63:0] m_lin;
	logic               v_d1;
	logic signed [31:0] p_d1;
	logic signed [31:0] sq_d1;
	logic signed [31:0] x2_d1;
	logic               err_d1;

	always_comb begin
		p_t   = sb2_d[DIV_STEPS-1].big ? $signed({quo2[30:0], 1'b0}) : $signed(quo2);
		p8_t  = p_t[31:8];
		m_p8  = p8_t * p8_t;
		m_lin = p_t * -32'sd7357;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_d1   <= p_t;
			sq_d1  <= m_p8[31:0];
			x2_d1  <= m_lin[47:16];
			err_d1 <= sb2_d[DIV_STEPS-1].err;
		end
	end

	// Stage d2: the quadratic correction term.
	logic signed [63:0] m_quad;
	logic               v_d2;
	logic signed [31:0] p_d2;
	logic signed [31:0] x1_d2;
	logic signed [31:0] x2_d2;
	logic               err_d2;

	assign m_quad = sq_d1 * 32'sd3038;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_d2   <= p_d1;
			x1_d2  <= m_quad[47:16];
			x2_d2  <= x2_d1;
			err_d2 <= err_d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d1 <= 1'b0;
			v_d2 <= 1'b0;
		end else if (adv) begin
			v_d1 <= v2_d[DIV_STEPS-1];
			v_d2 <= v_d1;
		end
	end

	// Output register: final correction, and zero pressure on a division fault.
	logic signed [31:0] corr_t;
	logic               res_valid_q;
	result_t            res_q;

	assign corr_t = x1_d2 + x2_d2 + 32'sd3791;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= v_d2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.pressure_pa <= err_d2 ? 32'sd0 : p_d2 + (corr_t >>> 4);
			res_q.status      <= err_d2 ? STATUS_DIV0 : STATUS_OK;
		end
	end

	assign adv          = !res_valid_q || result_ready;
	assign item_ready   = adv;
	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

`default_nettype wire

// File: rtl/bpc_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined unsigned restoring divider, one quotient bit per stage.
module bpc_div import bpc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [DIV_W-1:0] num,
	input  wire logic [DIV_W-1:0] den,
	output logic      [DIV_W-1:0] quo
);

	function automatic div_st_t div_step(input div_st_t s);
		logic [DIV_W:0] t;
		logic           ge;
		div_st_t        r;
		t       = {s.rem, s.num[DIV_W-1]};
		ge      = (t >= {1'b0, s.den});
		r.rem   = ge ? DIV_W'(t - {1'b0, s.den}) : t[DIV_W-1:0];
		r.num   = {s.num[DIV_W-2:0], 1'b0};
		r.quo   = {s.quo[DIV_W-2:0], ge};
		r.den   = s.den;
		return r;
	endfunction

	div_st_t step0;
	div_st_t step_s [1:DIV_STEPS];

	always_comb begin
		step0.rem = '0;
		step0.num = num;
		step0.quo = '0;
		step0.den = den;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			step_s[1] <= div_step(step0);
			for (int i = 1; i < DIV_STEPS; i++) step_s[i+1] <= div_step(step_s[i]);
		end
	end

	assign quo = step_s[DIV_STEPS].quo;

endmodule

`default_nettype wire

// File: rtl/bpc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bpc_checker import bpc_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    item_valid,
	input wire logic    item_ready,
	input wire item_t   item,
	input wire logic    result_valid,
	input wire logic    result_ready,
	input wire result_t result
);

	// A stalled input beat keeps its payload.
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_ready |=> item_valid && $stable(item))
		else $error("input beat changed while stalled");

	// A stalled result keeps its payload.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// With no result waiting, the block always takes input.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("input stalled with empty output");

	// A division fault always reports zero pressure.
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == STATUS_DIV0 |-> result.pressure_pa == 32'sd0)
		else $error("fault result with nonzero pressure");

endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

`default_nettype wire
